// ===== src/ptsc_pkg.sv =====
`timescale 1ns / 1ps
package ptsc_pkg;
  localparam int ADC_BITS = 10;
  localparam int NUM_W    = ADC_BITS + 6;
  localparam int QW       = 6;
  localparam int NCELL    = QW;

  localparam logic [2:0] ST_SET      = 3'd0;
  localparam logic [2:0] ST_DEAD     = 3'd1;
  localparam logic [2:0] ST_WRONG    = 3'd2;
  localparam logic [2:0] ST_HIGH_SAT = 3'd3;
  localparam logic [2:0] ST_LOW_SAT  = 3'd4;
  localparam logic [2:0] ST_CLOSE    = 3'd5;

  localparam logic [1:0] K_UP   = 2'd0;
  localparam logic [1:0] K_DOWN = 2'd1;
  localparam logic [1:0] K_DACB = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  typedef struct packed {
    logic             vld;
    logic [1:0]       kind;
    logic [2:0]       status;
    logic [5:0]       trim;
    logic             wtrim;
    logic [4:0]       dacb;
    logic             wsd;
    logic [NUM_W-1:0] rem;
    logic [ADC_BITS-1:0] den;
    logic [QW-1:0]    quo;
  } cell_t;
endpackage

// ===== src/ptsc_cell.sv =====
`timescale 1ns / 1ps
module ptsc_cell
  import ptsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cell_t in_c,
  output cell_t out_c
);
  cell_t c_r, c_nxt;
  logic [NUM_W:0] shd;
  logic [NUM_W-1:0] rem_d;
  logic qbit;

  // The divisor stays aligned to the top quotient bit; the partial remainder
  // moves up one place per cell and the new quotient bit enters at the bottom.
  always_comb begin
    c_nxt = in_c;
    shd = {1'b0, {(NUM_W-ADC_BITS){1'b0}}, in_c.den} << (QW-1);
    rem_d = in_c.rem;
    qbit = 1'b0;
    if (in_c.kind != K_DONE && {1'b0, in_c.rem} >= shd) begin
      rem_d = in_c.rem - shd[NUM_W-1:0];
      qbit  = 1'b1;
    end
    c_nxt.rem = {rem_d[NUM_W-2:0], 1'b0};
    c_nxt.quo = {in_c.quo[QW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else begin
      c_r.vld <= in_c.vld;
    end
    c_r.kind   <= c_nxt.kind;
    c_r.status <= c_nxt.status;
    c_r.trim   <= c_nxt.trim;
    c_r.wtrim  <= c_nxt.wtrim;
    c_r.dacb   <= c_nxt.dacb;
    c_r.wsd    <= c_nxt.wsd;
    c_r.rem    <= c_nxt.rem;
    c_r.den    <= c_nxt.den;
    c_r.quo    <= c_nxt.quo;
  end

  assign out_c = c_r;
endmodule

// ===== src/pedestal_trim_setting_calculator_top.sv =====
`timescale 1ns / 1ps
// Pedestal trim setting calculator. One channel beat is taken in every clock
// cycle (busy is tied low); its result passes the decode, cell and result
// registers to the out_ ports, marked by out_valid for one cycle. The receiver
// cannot stall the block, so results must be captured when out_valid is high.
// The pipeline is a decode stage, a row of six restoring-division cells
// (one quotient bit each, most significant first) and a finishing stage that
// forms trim, sign and DAC-B from the quotient. hcal_mode is written through
// cfg_wr_en/cfg_wr_data and must only change while no channel is in flight.
module pedestal_trim_setting_calculator_top
  import ptsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                start,
  output logic                busy,
  input  logic [ADC_BITS-1:0] in_baseline_level,
  input  logic [ADC_BITS-1:0] in_high_level,
  input  logic [ADC_BITS-1:0] in_low_level,
  input  logic [ADC_BITS-1:0] in_zero_level,
  input  logic [ADC_BITS-1:0] in_target_level,
  input  logic                in_dead_channel,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [5:0]          out_trim_value,
  output logic                out_write_trim,
  output logic                out_sign_value,
  output logic [4:0]          out_dacb_value,
  output logic                out_write_sign_dacb
);
  localparam int AW = ADC_BITS + 1;

  logic  hcal_r;
  cell_t dec_nxt, dec_r;
  cell_t chain [NCELL+1];

  logic signed [AW-1:0] b, h, l, z, t, num, den, td, dd, nd;
  logic [NUM_W-1:0] scaled;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcal_r <= 1'b0;
    end else if (cfg_wr_en) begin
      hcal_r <= cfg_wr_data;
    end
  end

  // Decode stage: classify the channel and set up numerator and divisor.
  // Ratios are scaled so that quotient = floor(k*num/den); ceiling cases add den-1.
  always_comb begin
    b = AW'(in_baseline_level);
    h = AW'(in_high_level);
    l = AW'(in_low_level);
    z = AW'(in_zero_level);
    t = AW'(in_target_level);
    td = b - z;
    dd = z - l;
    dec_nxt = '0;
    dec_nxt.vld  = start;
    dec_nxt.kind = K_DONE;
    dec_nxt.status = ST_SET;
    num = '0;
    den = '0;
    nd  = '0;
    scaled = '0;
    if (in_dead_channel) begin
      dec_nxt.status = ST_DEAD;
    end else if (b < t) begin
      num = t - b;
      den = h - b;
      if (den < 0) begin
        dec_nxt.status = ST_WRONG;
      end else if (den == 0 || num > den) begin
        dec_nxt.status = ST_HIGH_SAT;
        dec_nxt.trim = 6'd63;
        dec_nxt.wtrim = 1'b1;
      end else begin
        dec_nxt.kind = K_UP;
        dec_nxt.rem = (NUM_W'(num) << 5) - NUM_W'(num);
        dec_nxt.den = den[ADC_BITS-1:0];
      end
    end else begin
      num = b - t;
      den = b - l;
      if (num > 0 && den < 0) begin
        dec_nxt.status = ST_WRONG;
      end else if (num > 0 && (den == 0 || num > den)) begin
        dec_nxt.status = ST_LOW_SAT;
        dec_nxt.wtrim = 1'b1;
        if (hcal_r) begin
          dec_nxt.dacb = 5'd31;
          dec_nxt.wsd = 1'b1;
        end
      end else if (num == 0 && (!hcal_r || (td >= 0 && dd >= 0))) begin
        dec_nxt.trim = 6'd32;
        dec_nxt.wtrim = 1'b1;
      end else if (!hcal_r) begin
        dec_nxt.kind = K_DOWN;
        dec_nxt.rem = (NUM_W'(num) << 5) + NUM_W'(den) - NUM_W'(1);
        dec_nxt.den = den[ADC_BITS-1:0];
      end else if (td < 0 || dd < 0) begin
        dec_nxt.status = ST_WRONG;
      end else if (num <= td) begin
        dec_nxt.kind = K_DOWN;
        dec_nxt.rem = (NUM_W'(num) << 5) + NUM_W'(td) - NUM_W'(1);
        dec_nxt.den = td[ADC_BITS-1:0];
      end else begin
        // num - td <= dd always holds here, so the quotient stays within 31.
        nd = num - td;
        scaled = (NUM_W'(nd) << 5) - NUM_W'(nd);
        dec_nxt.kind = K_DACB;
        dec_nxt.rem = scaled;
        dec_nxt.den = dd[ADC_BITS-1:0];
        dec_nxt.wtrim = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.vld <= 1'b0;
    end else begin
      dec_r.vld <= dec_nxt.vld;
    end
    dec_r.kind   <= dec_nxt.kind;
    dec_r.status <= dec_nxt.status;
    dec_r.trim   <= dec_nxt.trim;
    dec_r.wtrim  <= dec_nxt.wtrim;
    dec_r.dacb   <= dec_nxt.dacb;
    dec_r.wsd    <= dec_nxt.wsd;
    dec_r.rem    <= dec_nxt.rem;
    dec_r.den    <= dec_nxt.den;
    dec_r.quo    <= dec_nxt.quo;
  end

  assign chain[0] = dec_r;

  // Division row: each cell resolves one quotient bit, most significant first.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ptsc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .in_c  (chain[i]),
      .out_c (chain[i+1])
    );
  end

  // Finishing stage: turn the quotient into settings.
  cell_t fin, res_nxt, res_r;
  logic [QW:0] down;
  always_comb begin
    fin = chain[NCELL];
    res_nxt = fin;
    down = 7'd32 - {1'b0, fin.quo};
    case (fin.kind)
      K_UP: begin
        res_nxt.trim  = 6'd32 + fin.quo;
        res_nxt.wtrim = 1'b1;
      end
      K_DOWN: begin
        if (down[QW] || down == '0) begin
          res_nxt.status = ST_CLOSE;
          res_nxt.trim = '0;
          res_nxt.wtrim = 1'b0;
        end else begin
          res_nxt.trim = down[5:0];
          res_nxt.wtrim = 1'b1;
        end
      end
      K_DACB: begin
        res_nxt.trim = '0;
        if (fin.quo == '0) begin
          res_nxt.status = ST_CLOSE;
        end else begin
          res_nxt.dacb = fin.quo[4:0];
          res_nxt.wsd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= fin.vld;
    end
    res_r.kind   <= res_nxt.kind;
    res_r.status <= res_nxt.status;
    res_r.trim   <= res_nxt.trim;
    res_r.wtrim  <= res_nxt.wtrim;
    res_r.dacb   <= res_nxt.dacb;
    res_r.wsd    <= res_nxt.wsd;
    res_r.rem    <= res_nxt.rem;
    res_r.den    <= res_nxt.den;
    res_r.quo    <= res_nxt.quo;
  end

  assign out_valid           = res_r.vld;
  assign out_status          = res_r.status;
  assign out_trim_value      = res_r.trim;
  assign out_write_trim      = res_r.wtrim;
  assign out_sign_value      = res_r.wsd;
  assign out_dacb_value      = res_r.dacb;
  assign out_write_sign_dacb = res_r.wsd;
endmodule
